[hw/rtl/ordered_queue_search_delete_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered queue
// Concurrent checks shared by the queue RTL, clocked and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_QUEUE_SEARCH_DELETE_UNIT_ASSERT_SVH
`define ORDERED_QUEUE_SEARCH_DELETE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OQSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define OQSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered queue check failed");

`endif

[hw/rtl/oqsd_pkg.sv]
// ----------------------------------------------------------------------------
// oqsd_pkg
// Beat types, codes and cell control structs for the ordered queue.
// ----------------------------------------------------------------------------
package oqsd_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int OCCUPANCY_BITS = 5;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      op_type    op;
      value_type value_in;
   } req_type;

   typedef struct packed {
      value_type                 value_out;
      logic                      found;
      status_type                status;
      logic [OCCUPANCY_BITS-1:0] occupancy;
   } rsp_type;

   // Broadcast to every cell in the apply cycle.
   typedef struct packed {
      logic push;
      logic shift_all;
      logic shift_marked;
   } cell_cmd_type;

   // Token and match flags handed from cell to cell during a sweep.
   typedef struct packed {
      logic tok;
      logic head_hit;
      logic tail_hit;
      logic mid_hit;
      logic any_hit;
   } sweep_type;

endpackage

[hw/rtl/oqsd_cell.sv]
// ----------------------------------------------------------------------------
// oqsd_cell
// One queue slot: holds an entry (the key on a push), matches it against the
// key as the sweep token passes, and takes its upper neighbour's on a shift.
// ----------------------------------------------------------------------------
module oqsd_cell #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [VALUE_WIDTH-1:0]        key,
   input  logic [$clog2(DEPTH+1)-1:0]    count,
   input  oqsd_pkg::cell_cmd_type        cmd,
   input  logic [VALUE_WIDTH-1:0]        upper_entry,
   input  oqsd_pkg::sweep_type           sweep_prev,
   output oqsd_pkg::sweep_type           sweep_next,
   output logic [VALUE_WIDTH-1:0]        entry
);

   localparam int CW = $clog2(DEPTH+1);

   logic [VALUE_WIDTH-1:0] entry_ff;
   oqsd_pkg::sweep_type    sweep_ff, sweep_in;
   logic                   shift_ff, shift_in;
   logic                   occupied, is_head, is_tail, is_mid, hit;

   always_comb begin
      occupied = CW'(INDEX) < count;
      is_head  = (INDEX == 0);
      is_tail  = (count == CW'(INDEX + 1));
      is_mid   = occupied && !is_head && !is_tail;
      hit      = sweep_prev.tok && occupied && (entry_ff == key);

      sweep_in.tok      = sweep_prev.tok;
      sweep_in.head_hit = sweep_prev.head_hit || (hit && is_head);
      sweep_in.tail_hit = sweep_prev.tail_hit || (hit && is_tail);
      sweep_in.mid_hit  = sweep_prev.mid_hit  || (hit && is_mid);
      sweep_in.any_hit  = sweep_prev.any_hit  || hit;

      // mark this slot when a middle match lies at or below it
      shift_in = shift_ff;
      if (sweep_prev.tok) begin
         shift_in = sweep_prev.mid_hit || (hit && is_mid);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         shift_ff <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && (count == CW'(INDEX))) begin
         entry_ff <= key;
      end else if (cmd.shift_all || (cmd.shift_marked && shift_ff)) begin
         entry_ff <= upper_entry;
      end
   end

   assign sweep_next = sweep_ff;
   assign entry      = entry_ff;

endmodule

[hw/rtl/ordered_queue_search_delete_unit.sv]
// ----------------------------------------------------------------------------
// ordered_queue_search_delete_unit
// Push and pop pass from the idle state through apply and done to the
// response beat; search and delete first sweep while a token walks the row.
// One operation is in flight: a new request is taken only once the last one
// has left the done state, which holds while the response side stalls;
// a finished response waits in the output register meanwhile.
// Synchronous reset empties the queue; entry storage is not cleared.
// ----------------------------------------------------------------------------
`include "ordered_queue_search_delete_unit_assert.svh"

module ordered_queue_search_delete_unit #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  oqsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output oqsd_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH+1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_APPLY,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [CW-1:0]          count_ff, count_in;
   oqsd_pkg::op_type       op_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic                   start_ff;
   oqsd_pkg::sweep_type    hits_ff;
   oqsd_pkg::rsp_type      res_ff, res_in;
   oqsd_pkg::rsp_type      rsp_data_ff;
   logic                   rsp_valid_ff;

   logic                   req_take, rsp_free, is_scan;
   oqsd_pkg::cell_cmd_type cmd;
   logic [VALUE_WIDTH-1:0] entry_q    [DEPTH];
   oqsd_pkg::sweep_type    sweep_link [DEPTH+1];

   // Only idle takes a request; the response register is separate, so a
   // waiting response does not hold off the next request.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign is_scan   = (req_data.op == oqsd_pkg::OP_SEARCH) ||
                      (req_data.op == oqsd_pkg::OP_DELETE);

   // Launch the token in the first cycle the registered key is valid.
   always_comb begin
      sweep_link[0]     = '0;
      sweep_link[0].tok = start_ff;
   end

   // Work out the queue update and the response in the apply cycle.
   always_comb begin
      cmd                = '0;
      count_in           = count_ff;
      res_in.value_out   = '0;
      res_in.found       = 1'b0;
      res_in.status      = oqsd_pkg::STATUS_DONE;
      case (op_ff)
         oqsd_pkg::OP_PUSH: begin
            if (count_ff == CW'(DEPTH)) begin
               res_in.status = oqsd_pkg::STATUS_FULL;
            end else begin
               cmd.push = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         oqsd_pkg::OP_POP: begin
            if (count_ff == '0) begin
               res_in.status = oqsd_pkg::STATUS_EMPTY;
            end else begin
               res_in.value_out = oqsd_pkg::value_type'($signed(entry_q[0]));
               cmd.shift_all    = 1'b1;
               count_in         = count_ff - CW'(1);
            end
         end
         oqsd_pkg::OP_SEARCH: begin
            res_in.found = hits_ff.any_hit;
         end
         oqsd_pkg::OP_DELETE: begin
            // head first, then tail, then the earliest middle match
            if (hits_ff.head_hit) begin
               res_in.found  = 1'b1;
               cmd.shift_all = 1'b1;
               count_in      = count_ff - CW'(1);
            end else if (hits_ff.tail_hit) begin
               res_in.found  = 1'b1;
               count_in      = count_ff - CW'(1);
            end else if (hits_ff.mid_hit) begin
               res_in.found     = 1'b1;
               cmd.shift_marked = 1'b1;
               count_in         = count_ff - CW'(1);
            end
         end
         default: begin
            res_in.status = oqsd_pkg::STATUS_DONE;
         end
      endcase
      res_in.occupancy = oqsd_pkg::OCCUPANCY_BITS'(count_in);
      if (state_ff != ST_APPLY) begin
         cmd      = '0;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= req_take && is_scan;
         count_ff <= count_in;
         // raise on a fresh response, drop once the waiting one is taken
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  op_ff  <= req_data.op;
                  key_ff <= VALUE_WIDTH'(req_data.value_in);
                  if (is_scan) begin
                     state_ff <= ST_SWEEP;
                  end else begin
                     state_ff <= ST_APPLY;
                  end
               end
            end
            ST_SWEEP: begin
               // hold until the token drops out of the last cell
               if (sweep_link[DEPTH].tok) begin
                  hits_ff  <= sweep_link[DEPTH];
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               res_ff   <= res_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Cell row: slot 0 is the head; each slot shifts down from the one above.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] upper;
      if (i == DEPTH - 1) begin : g_top
         assign upper = entry_q[i];
      end else begin : g_mid
         assign upper = entry_q[i+1];
      end
      oqsd_cell #(
         .DEPTH       (DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .key         (key_ff),
         .count       (count_ff),
         .cmd         (cmd),
         .upper_entry (upper),
         .sweep_prev  (sweep_link[i]),
         .sweep_next  (sweep_link[i+1]),
         .entry       (entry_q[i])
      );
   end

   // An accepted request beat closes the request side as the state leaves idle.
   `OQSD_ASSERT_NEXT(a_take_closes, clock, reset, req_take, req_stall)
   // The token only leaves the row while the controller waits for it.
   `OQSD_ASSERT_NOW(a_token_in_sweep, clock, reset, sweep_link[DEPTH].tok,
                    state_ff == ST_SWEEP)
   // Occupancy moves only in the apply cycle, and by at most one.
   `OQSD_ASSERT_NEXT(a_count_steady, clock, reset, state_ff != ST_APPLY,
                     count_ff == $past(count_ff))
   // A full flag can only leave with a full queue.
   `OQSD_ASSERT_NOW(a_full_means_full, clock, reset,
                    state_ff == ST_DONE && res_ff.status == oqsd_pkg::STATUS_FULL,
                    count_ff == CW'(DEPTH))

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered queue unit. A driver sends push, pop,
// search and delete beats from a backlog; every accepted request is run
// through a behavioural copy of the queue, and a monitor checks each
// response beat field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int RANDOM_ITEMS = 400;
   localparam int SEGMENT_LEN  = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = DEPTH + 12;
   localparam int MAX_REPORTS  = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   oqsd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   oqsd_pkg::rsp_type rsp_data;

   // Stimulus waiting to be sent, and replies predicted but not yet seen.
   oqsd_pkg::req_type   op_backlog[$];
   oqsd_pkg::rsp_type   pending_replies[$];
   // Behavioural copy of the queue contents, head at index 0.
   oqsd_pkg::value_type held_values[$];

   int total_items;
   int beats_taken = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   ordered_queue_search_delete_unit #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle schedule: first third the sender rarely pauses while the receiver
   // stalls heavily, second third the other way round, last third flat out.
   function automatic int sender_gap_pct(int taken);
      if (taken * 3 < total_items) return 9;
      else if (taken * 3 < total_items * 2) return 79;
      else return 0;
   endfunction

   function automatic int receiver_gap_pct(int taken);
      if (taken * 3 < total_items) return 79;
      else if (taken * 3 < total_items * 2) return 9;
      else return 0;
   endfunction

   // Apply one operation to the behavioural queue and return its reply.
   function automatic oqsd_pkg::rsp_type queue_outcome(oqsd_pkg::req_type r);
      oqsd_pkg::rsp_type reply;
      int      n;
      bit      hit;
      reply.value_out = '0;
      reply.found     = 1'b0;
      reply.status    = oqsd_pkg::STATUS_DONE;
      n = held_values.size();
      case (r.op)
         oqsd_pkg::OP_PUSH: begin
            if (n >= DEPTH) reply.status = oqsd_pkg::STATUS_FULL;
            else held_values.push_back(r.value_in);
         end
         oqsd_pkg::OP_POP: begin
            if (n == 0) reply.status = oqsd_pkg::STATUS_EMPTY;
            else reply.value_out = held_values.pop_front();
         end
         oqsd_pkg::OP_SEARCH: begin
            foreach (held_values[i])
               if (held_values[i] == r.value_in) reply.found = 1'b1;
         end
         default: begin
            // Head first, then tail, then the earliest middle entry.
            if (n != 0) begin
               if (held_values[0] == r.value_in) begin
                  reply.found = 1'b1;
                  held_values.delete(0);
               end else if (held_values[n-1] == r.value_in) begin
                  reply.found = 1'b1;
                  held_values.delete(n-1);
               end else begin
                  hit = 1'b0;
                  for (int i = 1; i < n - 1; i++) begin
                     if (!hit && held_values[i] == r.value_in) begin
                        hit = 1'b1;
                        reply.found = 1'b1;
                        held_values.delete(i);
                     end
                  end
               end
            end
         end
      endcase
      reply.occupancy = oqsd_pkg::OCCUPANCY_BITS'(held_values.size());
      return reply;
   endfunction

   task automatic add_item(oqsd_pkg::op_type op, oqsd_pkg::value_type value);
      oqsd_pkg::req_type r;
      r.op       = op;
      r.value_in = value;
      op_backlog.push_back(r);
   endtask

   // Driver: predict on every accepted request beat, then offer the next
   // beat unless this cycle is an idle one. Hold the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_replies.push_back(queue_outcome(req_data));
            beats_taken <= beats_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (op_backlog.size() != 0 &&
                $urandom_range(0, 99) >= sender_gap_pct(beats_taken)) begin
               req_valid <= 1'b1;
               req_data  <= op_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response beat against the oldest
   // prediction, then pick a fresh stall for the next cycle.
   always @(posedge clock) begin
      oqsd_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < MAX_REPORTS)
                  $display("unexpected beat: val %h fnd %b st %0d occ %0d",
                           rsp_data.value_out, rsp_data.found, rsp_data.status,
                           rsp_data.occupancy);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_data.value_out !== want.value_out || rsp_data.found !== want.found ||
                   rsp_data.status !== want.status ||
                   rsp_data.occupancy !== want.occupancy) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < MAX_REPORTS)
                     $display("mismatch cyc %0d (exp/act): val %h/%h fnd %b/%b",
                              cycle_count, want.value_out, rsp_data.value_out,
                              want.found, rsp_data.found,
                              " st %0d/%0d occ %0d/%0d",
                              want.status, rsp_data.status,
                              want.occupancy, rsp_data.occupancy);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_gap_pct(beats_taken));
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      oqsd_pkg::value_type pool[4];
      int                  pick;
      int                  mode;
      oqsd_pkg::op_type    op;
      oqsd_pkg::value_type value;

      // Directed part: empty-queue cases, sole-entry pop and delete, the
      // extreme values, and each of the delete priorities.
      add_item(oqsd_pkg::OP_POP,    $urandom);
      add_item(oqsd_pkg::OP_SEARCH, 32'h7fffffff);
      add_item(oqsd_pkg::OP_DELETE, 32'h80000000);
      add_item(oqsd_pkg::OP_PUSH,   32'h80000000);
      add_item(oqsd_pkg::OP_POP,    $urandom);
      add_item(oqsd_pkg::OP_PUSH,   32'd5);
      add_item(oqsd_pkg::OP_DELETE, 32'd5);
      add_item(oqsd_pkg::OP_PUSH,   32'h7fffffff);
      add_item(oqsd_pkg::OP_PUSH,   32'hffffffff);
      add_item(oqsd_pkg::OP_PUSH,   32'h00000000);
      add_item(oqsd_pkg::OP_PUSH,   32'hffffffff);
      add_item(oqsd_pkg::OP_SEARCH, 32'h00000000);
      add_item(oqsd_pkg::OP_SEARCH, 32'h00000001);
      // Tail wins over an earlier middle match.
      add_item(oqsd_pkg::OP_DELETE, 32'hffffffff);
      add_item(oqsd_pkg::OP_PUSH,   32'h00000000);
      add_item(oqsd_pkg::OP_DELETE, 32'h00000000);
      add_item(oqsd_pkg::OP_PUSH,   32'd5);
      // Middle match only.
      add_item(oqsd_pkg::OP_DELETE, 32'hffffffff);
      // Head match.
      add_item(oqsd_pkg::OP_DELETE, 32'h7fffffff);
      add_item(oqsd_pkg::OP_DELETE, 32'h00012345);
      add_item(oqsd_pkg::OP_POP,    $urandom);
      add_item(oqsd_pkg::OP_POP,    $urandom);
      add_item(oqsd_pkg::OP_POP,    $urandom);

      // Random part in segments: fill-heavy, drain-heavy and even mixes, so
      // the queue runs to full and back to empty repeatedly. Draw most
      // values from a small pool so searches and deletes find duplicates.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % SEGMENT_LEN == 0) begin
            case ($urandom_range(0, 3))
               0: pool[0] = 32'h80000000;
               1: pool[0] = 32'h7fffffff;
               2: pool[0] = 32'h00000000;
               default: pool[0] = 32'hffffffff;
            endcase
            for (int j = 1; j < 4; j++) pool[j] = $urandom;
         end
         mode = (k / SEGMENT_LEN) % 3;
         pick = $urandom_range(0, 99);
         case (mode)
            0: op = (pick < 60) ? oqsd_pkg::OP_PUSH : (pick < 70) ? oqsd_pkg::OP_POP :
                    (pick < 85) ? oqsd_pkg::OP_SEARCH : oqsd_pkg::OP_DELETE;
            1: op = (pick < 15) ? oqsd_pkg::OP_PUSH : (pick < 65) ? oqsd_pkg::OP_POP :
                    (pick < 80) ? oqsd_pkg::OP_SEARCH : oqsd_pkg::OP_DELETE;
            default: op = oqsd_pkg::op_type'(pick % 4);
         endcase
         if ($urandom_range(0, 9) < 7) value = pool[$urandom_range(0, 3)];
         else value = $urandom;
         add_item(op, value);
      end
      total_items = op_backlog.size();

      // Hold reset, then release it once.
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request beat to be taken, then for every reply.
      while (op_backlog.size() != 0 || req_valid) @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      // Let any stray beat surface before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

[ordered_queue_search_delete_unit.f]
+incdir+hw/rtl
hw/rtl/oqsd_pkg.sv
hw/rtl/oqsd_cell.sv
hw/rtl/ordered_queue_search_delete_unit.sv
verif/testbench.sv
